FILE: design/bvh_pkg.sv
// ----------------------------------------------------------------------------
// bvh_pkg
// Shared codes, field widths and controller/datapath handshake structs for
// the byte value histogram store.
// ----------------------------------------------------------------------------
`default_nettype none

package bvh_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned MCNT_W  = 32;
  localparam int unsigned OCNT_W  = 32;
  localparam int unsigned DIST_W  = 9;

  // operation codes; 5..7 are no-ops
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd2;
  localparam logic [OP_W-1:0] OP_MERGE  = 3'd3;
  localparam logic [OP_W-1:0] OP_SELECT = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture operands, issue bin read, reset scan
    logic rmw;        // finish add/query/merge
    logic scan_step;  // advance rank scan by one bin
    logic scan_done;  // finish select
    logic clear;      // finish clear
    logic nop;        // finish unknown operation
  } bvh_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;   // current scan bin is the requested rank
    logic last;  // current scan bin is the last one
  } bvh_stat_t;

endpackage

`default_nettype wire

FILE: design/byte_value_histogram_store.sv
// ----------------------------------------------------------------------------
// byte_value_histogram_store
// Histogram of byte values with distinct count and rank select.
//
//   channel  | handshake       | fields
//   ---------+-----------------+------------------------------------------------------
//   command  | start / busy    | operation_i byte_value_i merge_count_i rank_index_i
//   result   | done_o strobe   | found_o bin_count_o selected_value_o distinct_total_o
//
// A command transfers on a rising edge with start high and busy low.
// Add, query, merge, clear and unknown codes: a work state (RMW, CLEAR or NOP), then
//   done_o; the bin read is registered, so it is issued at the transfer and the write follows in RMW.
// Select: one bitmap bin per cycle until the rank hits or the last bin is reached.
// done_o lasts one cycle and the receiver cannot stall; busy is already low then.
// Reset clears the nonzero bitmap and distinct count at once; no memory sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_value_histogram_store #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned NUM_BINS    = 256
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // command channel
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [bvh_pkg::OP_W-1:0]     operation_i,
  input  wire logic [bvh_pkg::BYTE_W-1:0]   byte_value_i,
  input  wire logic [bvh_pkg::MCNT_W-1:0]   merge_count_i,
  input  wire logic [bvh_pkg::BYTE_W-1:0]   rank_index_i,
  // result channel
  output logic                              done_o,
  output logic                              found_o,
  output logic [bvh_pkg::OCNT_W-1:0]        bin_count_o,
  output logic [bvh_pkg::BYTE_W-1:0]        selected_value_o,
  output logic [bvh_pkg::DIST_W-1:0]        distinct_total_o
);

  bvh_pkg::bvh_cmd_t  cmd;
  bvh_pkg::bvh_stat_t stat;

  // sequencer: one command in flight at a time
  bvh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy        (busy),
    .done_o      (done_o)
  );

  // bins, bitmap, saturating adder and scan counters
  bvh_dpath #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .NUM_BINS    (NUM_BINS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .operation_i      (operation_i),
    .byte_value_i     (byte_value_i),
    .merge_count_i    (merge_count_i),
    .rank_index_i     (rank_index_i),
    .found_o          (found_o),
    .bin_count_o      (bin_count_o),
    .selected_value_o (selected_value_o),
    .distinct_total_o (distinct_total_o)
  );

`ifndef SYNTHESIS
  // a finished command always frees the command channel
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while busy");

  // every transfer starts work and raises busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("command transfer did not start work");

  // every command passes through a work state before done_o, so strobes never abut
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("back-to-back result strobes");

  // distinct count can never exceed the number of bins
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   distinct_total_o <= bvh_pkg::DIST_W'(NUM_BINS))
    else $error("distinct count above bin count");

  // a select result carries no bin count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (done_o && selected_value_o != '0) |-> (bin_count_o == '0))
    else $error("select result with nonzero bin count");
`endif

endmodule

`default_nettype wire

FILE: design/bvh_ctrl.sv
// ----------------------------------------------------------------------------
// bvh_ctrl
// Sequencer for the histogram store: decodes the operation and steps the
// datapath through read-modify-write, rank scan or clear.
// ----------------------------------------------------------------------------
`default_nettype none

module bvh_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  input  wire logic [bvh_pkg::OP_W-1:0]   operation_i,
  input  wire bvh_pkg::bvh_stat_t         stat_i,
  output bvh_pkg::bvh_cmd_t               cmd_o,
  output logic                            busy,
  output logic                            done_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RMW,
    S_SCAN,
    S_CLEAR,
    S_NOP
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          case (operation_i)
            bvh_pkg::OP_ADD,
            bvh_pkg::OP_QUERY,
            bvh_pkg::OP_MERGE:  state_d = S_RMW;
            bvh_pkg::OP_SELECT: state_d = S_SCAN;
            bvh_pkg::OP_CLEAR:  state_d = S_CLEAR;
            default:            state_d = S_NOP;
          endcase
        end
      end
      S_RMW: begin
        cmd_o.rmw = 1'b1;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end
      S_SCAN: begin
        if (stat_i.hit || stat_i.last) begin
          cmd_o.scan_done = 1'b1;
          done_d          = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        done_d      = 1'b1;
        state_d     = S_IDLE;
      end
      S_NOP: begin
        cmd_o.nop = 1'b1;
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: design/bvh_dpath.sv
// ----------------------------------------------------------------------------
// bvh_dpath
// Bin memory, nonzero bitmap, saturating adder, distinct counter and rank
// scan counters of the histogram store.
// ----------------------------------------------------------------------------
`default_nettype none

module bvh_dpath #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned NUM_BINS    = 256
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bvh_pkg::bvh_cmd_t            cmd_i,
  output bvh_pkg::bvh_stat_t                stat_o,
  input  wire logic [bvh_pkg::OP_W-1:0]     operation_i,
  input  wire logic [bvh_pkg::BYTE_W-1:0]   byte_value_i,
  input  wire logic [bvh_pkg::MCNT_W-1:0]   merge_count_i,
  input  wire logic [bvh_pkg::BYTE_W-1:0]   rank_index_i,
  output logic                              found_o,
  output logic [bvh_pkg::OCNT_W-1:0]        bin_count_o,
  output logic [bvh_pkg::BYTE_W-1:0]        selected_value_o,
  output logic [bvh_pkg::DIST_W-1:0]        distinct_total_o
);

  localparam int unsigned AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned CW = COUNT_WIDTH;

  // bin storage; an entry is meaningful only while its nonzero bit is set
  logic [CW-1:0] mem [NUM_BINS];
  logic [CW-1:0] rd_q;

  logic [NUM_BINS-1:0]              nz_q;
  logic [bvh_pkg::DIST_W-1:0]       distinct_q;
  logic [AW-1:0]                    idx_q;
  logic [bvh_pkg::DIST_W-1:0]       seen_q;

  // latched operands
  logic [bvh_pkg::OP_W-1:0]   op_q;
  logic [bvh_pkg::BYTE_W-1:0] bv_q;
  logic [bvh_pkg::MCNT_W-1:0] mc_q;
  logic [bvh_pkg::BYTE_W-1:0] rank_q;

  // result registers
  logic                       found_q;
  logic [CW-1:0]              cnt_q;
  logic [bvh_pkg::BYTE_W-1:0] sel_q;

  logic [AW-1:0]              bv_idx;
  logic                       in_range;
  logic                       old_nz;
  logic [CW-1:0]              old_cnt;
  logic [CW+31:0]             mc_ext;
  logic [CW-1:0]              addend;
  logic [CW:0]                sum;
  logic [CW-1:0]              new_cnt;
  logic                       is_query;
  logic                       rmw_found;
  logic                       wr_en;
  logic [CW-1:0]              rmw_cnt;
  logic [AW+7:0]              idx_ext;
  logic [CW+31:0]             cnt_ext;

  assign bv_idx   = bv_q[AW-1:0];
  assign in_range = ({1'b0, bv_q} < bvh_pkg::DIST_W'(NUM_BINS));
  assign old_nz   = in_range && nz_q[bv_idx];
  assign old_cnt  = old_nz ? rd_q : '0;
  assign is_query = (op_q == bvh_pkg::OP_QUERY);

  // merge count truncated or zero-extended to the counter width
  assign mc_ext  = {{CW{1'b0}}, mc_q};
  assign addend  = (op_q == bvh_pkg::OP_ADD) ? {{(CW-1){1'b0}}, 1'b1} : mc_ext[CW-1:0];
  assign sum     = {1'b0, old_cnt} + {1'b0, addend};
  assign new_cnt = sum[CW] ? '1 : sum[CW-1:0];

  assign rmw_found = in_range && (is_query ? old_nz : (!old_nz && (new_cnt != '0)));
  assign wr_en     = cmd_i.rmw && in_range && !is_query;
  assign rmw_cnt   = !in_range ? '0 : (is_query ? old_cnt : new_cnt);

  assign stat_o.hit  = nz_q[idx_q] && (seen_q == {1'b0, rank_q});
  assign stat_o.last = (idx_q == AW'(NUM_BINS - 1));

  assign idx_ext = {8'b0, idx_q};

  // memory port: read at operand capture, write at end of read-modify-write
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_q <= mem[byte_value_i[AW-1:0]];
    end
    if (wr_en) begin
      mem[bv_idx] <= new_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_q       <= '0;
      distinct_q <= '0;
      idx_q      <= '0;
      seen_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        idx_q  <= '0;
        seen_q <= '0;
      end
      if (cmd_i.scan_step) begin
        idx_q <= idx_q + AW'(1);
        if (nz_q[idx_q]) begin
          seen_q <= seen_q + bvh_pkg::DIST_W'(1);
        end
      end
      if (wr_en && (new_cnt != '0)) begin
        nz_q[bv_idx] <= 1'b1;
      end
      if (cmd_i.rmw && rmw_found && !is_query) begin
        distinct_q <= distinct_q + bvh_pkg::DIST_W'(1);
      end
      if (cmd_i.clear) begin
        nz_q       <= '0;
        distinct_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      bv_q   <= byte_value_i;
      mc_q   <= merge_count_i;
      rank_q <= rank_index_i;
    end
    if (cmd_i.rmw) begin
      found_q <= rmw_found;
      cnt_q   <= rmw_cnt;
      sel_q   <= '0;
    end
    if (cmd_i.scan_done) begin
      found_q <= stat_o.hit;
      cnt_q   <= '0;
      sel_q   <= stat_o.hit ? idx_ext[7:0] : '0;
    end
    if (cmd_i.clear || cmd_i.nop) begin
      found_q <= 1'b0;
      cnt_q   <= '0;
      sel_q   <= '0;
    end
  end

  assign cnt_ext          = {32'b0, cnt_q};
  assign found_o          = found_q;
  assign bin_count_o      = cnt_ext[31:0];
  assign selected_value_o = sel_q;
  assign distinct_total_o = distinct_q;

endmodule

`default_nettype wire
